// ===== rtl/core/ptts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task table scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int PERIOD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef logic [2:0] slot_idx_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        high_priority;
    logic [15:0] period_ticks;
    logic [7:0]  task_ident;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic       add_ok;
    slot_idx_t  slot_index;
    logic [7:0] dispatched_ident;
    logic       last_of_run;
  } out_word_t;

  // commands from the sequencer to the slot datapath
  typedef struct packed {
    logic load;
    logic add_try;
    logic add_last;
    logic walk;
    logic walk_disp;
  } dp_cmd_t;

endpackage

// ===== rtl/core/periodic_task_table_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler_top
// Task slot table with add, tick and dispatch commands.
// ----------------------------------------------------------------------------
// Usage: raise start with a word on in_data while busy is low; the word is
// taken at that edge and busy stays high until the command has finished.
// Opcodes: add claims a slot (lowest free for high priority, highest free
// otherwise) and gives one status word; tick counts down every valid slot
// and gives nothing; dispatch gives one word per pending slot, lowest
// index first, with last_of_run set on the final one.
// Timing: add scans one slot per cycle, status word out on the cycle after
// the free slot is found. Tick and dispatch walk the slot memories one
// slot per cycle through a two-stage read-modify-write, and a dispatched
// word is registered after the second stage. A disabled tick ends at once.
// Results: out_valid pulses for one cycle with out_data; the receiver
// cannot stall, so every word is taken as it appears.
// Configuration: cfg_data is the scheduler enable, written when cfg_valid
// is high (cfg_ready always high); the user must write it only while the
// block is idle, since the block itself does not enforce this.
// Reset: table empty, scheduler disabled, no result pending.
// ----------------------------------------------------------------------------
module periodic_task_table_scheduler_top import ptts_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] idx;
  logic             slot_free;

  assign cfg_ready = 1'b1;

  ptts_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .opcode        (in_data.opcode),
    .high_priority (in_data.high_priority),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .slot_free     (slot_free),
    .busy          (busy),
    .cmd           (cmd),
    .idx           (idx)
  );

  ptts_dpath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .in_data   (in_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/ptts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: decodes a word, walks the slot index and holds the enable bit.
// ----------------------------------------------------------------------------
module ptts_ctrl import ptts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  opcode_t          opcode,
  input  logic             high_priority,
  input  logic             cfg_wr,
  input  logic             cfg_data,
  input  logic             slot_free,
  output logic             busy,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] idx
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADD   = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hi_pri_r, hi_pri_nxt;
  logic             disp_r, disp_nxt;
  logic             enabled_r;
  logic             add_last;

  assign busy = (state_r != ST_IDLE);
  assign idx  = idx_r;
  assign add_last = hi_pri_r ? (idx_r == IDX_LAST) : (idx_r == '0);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hi_pri_nxt    = hi_pri_r;
    disp_nxt      = disp_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          unique case (opcode)
            OP_ADD: begin
              state_nxt  = ST_ADD;
              hi_pri_nxt = high_priority;
              idx_nxt    = high_priority ? '0 : IDX_LAST;
            end
            OP_TICK: begin
              if (enabled_r) begin
                state_nxt = ST_WALK;
                idx_nxt   = '0;
                disp_nxt  = 1'b0;
              end
            end
            OP_DISPATCH: begin
              state_nxt = ST_WALK;
              idx_nxt   = '0;
              disp_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        cmd.add_try  = 1'b1;
        cmd.add_last = add_last;
        if (slot_free || add_last) begin
          state_nxt = ST_IDLE;
        end else if (hi_pri_r) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_WALK: begin
        cmd.walk      = 1'b1;
        cmd.walk_disp = disp_r;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last slot still in the second stage
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      hi_pri_r  <= 1'b0;
      disp_r    <= 1'b0;
      enabled_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      hi_pri_r <= hi_pri_nxt;
      disp_r   <= disp_nxt;
      if (cfg_wr) begin
        enabled_r <= cfg_data;
      end
    end
  end

endmodule

// ===== rtl/core/ptts_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_dpath
// Slot table: period, countdown and id memories, valid and pending flags,
// two-stage read-modify-write walk and the result register.
// ----------------------------------------------------------------------------
module ptts_dpath import ptts_pkg::*; #(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [IDX_W-1:0] idx,
  input  in_word_t         in_data,
  output logic             slot_free,
  output logic             out_valid,
  output out_word_t        out_data
);

  logic [PERIOD_BITS-1:0] per_mem [NUM_SLOTS];
  logic [PERIOD_BITS-1:0] cnt_mem [NUM_SLOTS];
  logic [7:0]             id_mem  [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]   valid_r;
  logic [NUM_SLOTS-1:0]   pend_r;

  logic [PERIOD_BITS-1:0] per_q_r;
  logic [7:0]             id_q_r;

  logic [PERIOD_BITS-1:0] rd_per_r;
  logic [PERIOD_BITS-1:0] rd_cnt_r;
  logic [7:0]             rd_id_r;

  logic                   s1_vld_r;
  logic                   s1_disp_r;
  logic [IDX_W-1:0]       s1_idx_r;

  logic                   out_vld_r, out_vld_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   add_wr;
  logic                   s1_slot;
  logic                   tick_act;
  logic                   disp_emit;
  logic [PERIOD_BITS-1:0] cnt_dec;
  logic                   cnt_wr;
  logic [PERIOD_BITS-1:0] cnt_wdata;
  logic                   tick_pend;
  logic [NUM_SLOTS-1:0]   vp;
  logic [NUM_SLOTS-1:0]   vp_above;
  logic [IDX_W-1:0]       cnt_addr;

  assign slot_free = ~valid_r[idx];
  assign add_wr    = cmd.add_try && slot_free;

  assign s1_slot   = s1_vld_r && valid_r[s1_idx_r];
  assign tick_act  = s1_slot && !s1_disp_r;
  assign disp_emit = s1_slot && s1_disp_r && pend_r[s1_idx_r];

  // countdown update for one slot, or its initial load on an add
  always_comb begin
    cnt_dec   = rd_cnt_r - PERIOD_BITS'(1);
    cnt_wr    = 1'b0;
    cnt_wdata = cnt_dec;
    tick_pend = 1'b0;
    if (tick_act) begin
      if (rd_cnt_r != '0) begin
        cnt_wr = 1'b1;
        if (cnt_dec == '0) begin
          tick_pend = 1'b1;
          cnt_wdata = rd_per_r;
        end
      end else if (rd_per_r == '0) begin
        tick_pend = 1'b1;
      end
    end
    if (add_wr) begin
      cnt_wr    = 1'b1;
      cnt_wdata = per_q_r;
    end
  end

  assign cnt_addr = add_wr ? idx : s1_idx_r;

  // anything still pending above the slot being sent
  assign vp       = valid_r & pend_r;
  assign vp_above = (vp >> s1_idx_r) >> 1;

  always_comb begin
    out_vld_nxt  = 1'b0;
    out_data_nxt = out_data_r;
    if (cmd.add_try && (slot_free || cmd.add_last)) begin
      out_vld_nxt                   = 1'b1;
      out_data_nxt.result_kind      = KIND_ADD;
      out_data_nxt.add_ok           = slot_free;
      out_data_nxt.slot_index       = slot_free ? slot_idx_t'(idx) : '0;
      out_data_nxt.dispatched_ident = '0;
      out_data_nxt.last_of_run      = 1'b1;
    end else if (disp_emit) begin
      out_vld_nxt                   = 1'b1;
      out_data_nxt.result_kind      = KIND_DISPATCH;
      out_data_nxt.add_ok           = 1'b0;
      out_data_nxt.slot_index       = slot_idx_t'(s1_idx_r);
      out_data_nxt.dispatched_ident = rd_id_r;
      out_data_nxt.last_of_run      = (vp_above == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      per_mem[idx] <= per_q_r;
    end
    rd_per_r <= per_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    rd_cnt_r <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      id_mem[idx] <= id_q_r;
    end
    rd_id_r <= id_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (add_wr) begin
      pend_r[idx] <= 1'b0;
    end else if (tick_pend) begin
      pend_r[s1_idx_r] <= 1'b1;
    end else if (disp_emit && (rd_per_r != '0)) begin
      pend_r[s1_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      per_q_r <= PERIOD_BITS'(in_data.period_ticks);
      id_q_r  <= in_data.task_ident;
    end
    s1_disp_r  <= cmd.walk_disp;
    s1_idx_r   <= idx;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (add_wr) begin
        valid_r[idx] <= 1'b1;
      end
      s1_vld_r  <= cmd.walk;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/tb_periodic_task_table_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_table_scheduler_top
// Self-checking bench for the task slot table scheduler. A fixed run of add,
// tick and dispatch words fills the table and walks the enable through both
// values, then random words are pushed in phases with the enable rewritten
// between phases. Every result word is compared with an expected word, typed
// in for the fixed adds and from a behavioural copy of the table otherwise.
// ----------------------------------------------------------------------------
module tb_periodic_task_table_scheduler_top;
  import ptts_pkg::*;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int PHASES      = 5;
  localparam int PHASE_WORDS = 50;

  typedef struct packed {
    logic      is_cfg;
    logic      cfg_val;
    logic      typed;
    in_word_t  word;
    out_word_t want;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  // behavioural copy of the slot table
  logic        sched_on;
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_period [SLOTS];
  logic [15:0] tbl_count [SLOTS];
  logic        tbl_pend [SLOTS];
  logic [7:0]  tbl_ident [SLOTS];

  out_word_t owed_words[$];
  int        fails = 0;

  periodic_task_table_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // works out the words a command gives and updates the table copy
  task automatic table_step(input in_word_t w, input bit emit);
    int        i;
    int        found;
    out_word_t r;
    out_word_t run[$];
    found = -1;
    case (w.opcode)
      OP_ADD: begin
        if (w.high_priority) begin
          for (i = 0; i < SLOTS; i++)
            if (!tbl_valid[i] && found < 0) found = i;
        end else begin
          for (i = SLOTS - 1; i >= 0; i--)
            if (!tbl_valid[i] && found < 0) found = i;
        end
        r = '0;
        r.result_kind = KIND_ADD;
        r.last_of_run = 1'b1;
        if (found >= 0) begin
          tbl_period[found] = w.period_ticks;
          tbl_count[found]  = w.period_ticks;
          tbl_pend[found]   = 1'b0;
          tbl_ident[found]  = w.task_ident;
          tbl_valid[found]  = 1'b1;
          r.add_ok     = 1'b1;
          r.slot_index = slot_idx_t'(found);
        end
        run.push_back(r);
      end
      OP_TICK: begin
        if (sched_on) begin
          for (i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
              if (tbl_count[i] != 0) begin
                tbl_count[i] = tbl_count[i] - 16'd1;
                if (tbl_count[i] == 0) begin
                  tbl_pend[i]  = 1'b1;
                  tbl_count[i] = tbl_period[i];
                end
              end else if (tbl_period[i] == 0) begin
                tbl_pend[i] = 1'b1;
              end
            end
          end
        end
      end
      OP_DISPATCH: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_pend[i]) begin
            r = '0;
            r.result_kind      = KIND_DISPATCH;
            r.slot_index       = slot_idx_t'(i);
            r.dispatched_ident = tbl_ident[i];
            run.push_back(r);
            // period zero slots stay pending
            if (tbl_period[i] != 0) tbl_pend[i] = 1'b0;
          end
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      end
      default: ;
    endcase
    if (emit)
      foreach (run[k]) owed_words.push_back(run[k]);
  endtask

  function automatic step_row_t cmd(input opcode_t op, input logic hp,
                                    input logic [15:0] per, input logic [7:0] id);
    step_row_t s;
    s = '0;
    s.word.opcode        = op;
    s.word.high_priority = hp;
    s.word.period_ticks  = per;
    s.word.task_ident    = id;
    return s;
  endfunction

  // add with the status word typed in
  function automatic step_row_t add_row(input logic hp, input logic [15:0] per,
                                        input logic [7:0] id, input logic ok,
                                        input slot_idx_t slot);
    step_row_t s;
    s = cmd(OP_ADD, hp, per, id);
    s.typed            = 1'b1;
    s.want.result_kind = KIND_ADD;
    s.want.add_ok      = ok;
    s.want.slot_index  = slot;
    s.want.last_of_run = 1'b1;
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic v);
    step_row_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    start   = 1'b1;
    in_data = w;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) begin
      table_step(w, 1'b0);
      owed_words.push_back(want);
    end else begin
      table_step(w, 1'b1);
    end
    @(negedge clk);
  endtask

  task automatic idle_gap(input bit quiet);
    int n;
    int r;
    n = 0;
    r = $urandom_range(0, 99);
    if (!quiet) begin
      if (r >= 92) n = $urandom_range(8, 40);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // enable is only rewritten once the block has drained
  task automatic write_enable(input logic v);
    start = 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sched_on = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_word(input out_word_t got, input out_word_t want);
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      fails++;
    end
    if (got.add_ok !== want.add_ok) begin
      $error("add_ok: expected %0d, got %0d", want.add_ok, got.add_ok);
      fails++;
    end
    if (got.slot_index !== want.slot_index) begin
      $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
      fails++;
    end
    if (got.dispatched_ident !== want.dispatched_ident) begin
      $error("dispatched_ident: expected %0d, got %0d",
             want.dispatched_ident, got.dispatched_ident);
      fails++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (owed_words.size() == 0) begin
        $error("unexpected result word: %h", out_data);
        fails++;
      end else begin
        check_word(out_data, owed_words.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_periodic_task_table_scheduler_top failed");
    $finish;
  end

  initial begin
    step_row_t rows[$];
    in_word_t  w;
    int        pick;
    logic      en;

    sched_on = 1'b0;
    foreach (tbl_valid[i]) begin
      tbl_valid[i]  = 1'b0;
      tbl_period[i] = '0;
      tbl_count[i]  = '0;
      tbl_pend[i]   = 1'b0;
      tbl_ident[i]  = '0;
    end

    // disabled: empty dispatch, ignored tick, no-op opcode, first adds, tick and dispatch
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_TICK, 1'b1, 16'hFFFF, 8'hFF));
    rows.push_back(cmd(OP_NOP, 1'b1, 16'hFFFF, 8'hFF));
    rows.push_back(add_row(1'b1, 16'h0000, 8'h00, 1'b1, 3'd0));
    rows.push_back(add_row(1'b0, 16'hFFFF, 8'hFF, 1'b1, 3'd7));
    rows.push_back(add_row(1'b1, 16'h0001, 8'hA5, 1'b1, 3'd1));
    rows.push_back(add_row(1'b0, 16'h0002, 8'h5A, 1'b1, 3'd6));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));
    // enabled: period zero stays pending across dispatches
    rows.push_back(cfg_row(1'b1));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b1, 16'hFFFF, 8'hFF));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));
    // fill the table from both ends, overflow it, then tick and dispatch enabled and disabled
    rows.push_back(add_row(1'b1, 16'h0003, 8'h80, 1'b1, 3'd2));
    rows.push_back(add_row(1'b0, 16'h0005, 8'h7F, 1'b1, 3'd5));
    rows.push_back(add_row(1'b1, 16'h0004, 8'h3C, 1'b1, 3'd3));
    rows.push_back(add_row(1'b0, 16'h0007, 8'hC3, 1'b1, 3'd4));
    rows.push_back(add_row(1'b1, 16'h0001, 8'h11, 1'b0, 3'd0));
    rows.push_back(add_row(1'b0, 16'hFFFF, 8'hFF, 1'b0, 3'd0));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cfg_row(1'b0));
    rows.push_back(cmd(OP_TICK, 1'b0, 16'h0000, 8'h00));
    rows.push_back(cmd(OP_DISPATCH, 1'b0, 16'h0000, 8'h00));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_enable(rows[i].cfg_val);
      end else begin
        send_word(rows[i].word, rows[i].typed, rows[i].want);
        idle_gap(1'b0);
      end
    end

    // table is full from here on, so ticks and dispatches carry the load
    for (int p = 0; p < PHASES; p++) begin
      en = (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      write_enable(en);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        pick = $urandom_range(0, 99);
        w.high_priority = 1'($urandom_range(0, 1));
        w.period_ticks  = 16'($urandom_range(0, 65535));
        w.task_ident    = 8'($urandom_range(0, 255));
        if (pick < 45) w.opcode = OP_TICK;
        else if (pick < 80) w.opcode = OP_DISPATCH;
        else if (pick < 92) w.opcode = OP_ADD;
        else w.opcode = OP_NOP;
        send_word(w, 1'b0, '0);
        idle_gap(p == 3);
      end
    end

    start = 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (3 * SLOTS + 10) @(posedge clk);
    if (fails == 0) begin
      $display("tb_periodic_task_table_scheduler_top passed");
    end else begin
      $display("tb_periodic_task_table_scheduler_top failed");
    end
    $finish;
  end

endmodule
